// File: hw/rtl/pusb_pkg.sv
`timescale 1ns / 1ps

package pusb_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned COEF_W      = 16;
    localparam int unsigned FMT_W       = 3;
    localparam int unsigned NUM_CHAN    = 4;
    localparam int unsigned NUM_REGS    = 8;
    localparam int unsigned REG_IDX_W   = 3;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 32;

    // Q8.8 coefficient reset values
    localparam logic signed [COEF_W-1:0] SCALE_ONE = 16'sd256;
    localparam logic signed [COEF_W-1:0] BIAS_ZERO = 16'sd0;

    // Clamp ceiling (255 << 8) and rounding offset (one half LSB of the result)
    localparam logic [15:0] CLAMP_MAX  = 16'hFF00;
    localparam logic [16:0] ROUND_HALF = 17'd128;

    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [BYTE_W-1:0] CHAN_ZERO    = 8'h00;

    typedef enum logic [FMT_W-1:0] {
        FMT_RGBA  = 3'd0,
        FMT_BGRA  = 3'd1,
        FMT_RGB   = 3'd2,
        FMT_LUM   = 3'd3,
        FMT_ALPHA = 3'd4
    } pixel_format_t;

    // Register index map: bit 2 selects bias over scale, bits 1:0 the channel
    localparam logic [REG_IDX_W-1:0] REG_RED_SCALE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RED_BIAS  = 3'd4;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2,
        CH_ALPHA = 2'd3
    } chan_t;

endpackage

// File: hw/rtl/pusb_channel.sv
`timescale 1ns / 1ps

// One channel of the pixel transfer: v*scale + bias*255, clamp, round.
module pusb_channel (
    input  logic [pusb_pkg::BYTE_W-1:0]        value,
    input  logic signed [pusb_pkg::COEF_W-1:0] scale,
    input  logic signed [pusb_pkg::COEF_W-1:0] bias,
    output logic [pusb_pkg::BYTE_W-1:0]        result
);

    logic signed [24:0] product;
    logic signed [23:0] bias_full;
    logic signed [25:0] sum;
    logic [15:0]        clamped;
    logic [16:0]        rounded;

    // 9x16 signed multiply; value is zero-extended to stay positive
    assign product = $signed({16'd0, value}) * $signed({{9{scale[15]}}, scale});

    // bias * 255 as (bias << 8) - bias
    assign bias_full = $signed({bias, 8'h00}) - $signed({{8{bias[15]}}, bias});

    assign sum = $signed({product[24], product}) + $signed({{2{bias_full[23]}}, bias_full});

    always_comb
    begin
        if (sum[25])
        begin
            clamped = 16'h0000;
        end
        else if (sum > $signed({10'd0, pusb_pkg::CLAMP_MAX}))
        begin
            clamped = pusb_pkg::CLAMP_MAX;
        end
        else
        begin
            clamped = sum[15:0];
        end
    end

    assign rounded = {1'b0, clamped} + pusb_pkg::ROUND_HALF;
    assign result  = rounded[15:8];

endmodule

// File: hw/rtl/pixel_unpack_scale_bias_unit.sv
`timescale 1ns / 1ps

// Pixel unpack with scale and bias. Each input word carries one source pixel
// (format code plus up to four bytes); the block expands it to RGBA8 (missing
// alpha reads as 255, missing color as 0 or the luminance byte) and runs each
// channel through out = (clamp(v*scale + bias*255, 0, 255<<8) + 128) >> 8 with
// signed Q8.8 scale and bias registers. Format codes 5..7 decode as alpha.
// A word passes an input register, then one 9x16 multiply-add per channel
// into the result register, which holds it until the output side takes it.
// One word is accepted every cycle as long as the output side keeps taking
// words. Scale and bias registers reset to 1.0 and 0.0 (identity) and should
// only be written while no word is in flight; writes take effect the next
// cycle.
module pixel_unpack_scale_bias_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,

    // Configuration write port
    input  logic                                 cfg_we,
    input  logic [pusb_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [pusb_pkg::COEF_W-1:0]          cfg_wdata,

    // Input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [2:0] pixel_format, [10:3] byte_zero, [18:11] byte_one,
    // [26:19] byte_two, [34:27] byte_three, [39:35] zero
    input  logic [pusb_pkg::IN_TDATA_W-1:0]      s_tdata,

    // Output stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [7:0] red_out, [15:8] green_out, [23:16] blue_out, [31:24] alpha_out
    output logic [pusb_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int unsigned BW = pusb_pkg::BYTE_W;

    // ---- configuration registers ----
    logic signed [pusb_pkg::COEF_W-1:0] scale_reg [pusb_pkg::NUM_CHAN];
    logic signed [pusb_pkg::COEF_W-1:0] bias_reg  [pusb_pkg::NUM_CHAN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pusb_pkg::NUM_CHAN; i++)
            begin
                scale_reg[i] <= pusb_pkg::SCALE_ONE;
                bias_reg[i]  <= pusb_pkg::BIAS_ZERO;
            end
        end
        else if (cfg_we)
        begin
            // every 3-bit index maps onto the list; bit 2 picks bias
            if (cfg_index[2] == pusb_pkg::REG_RED_BIAS[2])
            begin
                bias_reg[cfg_index[1:0]] <= cfg_wdata;
            end
            else
            begin
                scale_reg[cfg_index[1:0]] <= cfg_wdata;
            end
        end
    end

    // ---- pipeline control ----
    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;      // result register can take a new word
    logic in_fire;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign in_fire  = s_tvalid && s_tready;

    // ---- input register ----
    logic [pusb_pkg::FMT_W-1:0] fmt_reg;
    logic [BW-1:0]              bytes_reg [pusb_pkg::NUM_CHAN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            fmt_reg      <= s_tdata[pusb_pkg::FMT_W-1:0];
            bytes_reg[0] <= s_tdata[pusb_pkg::FMT_W          +: BW];
            bytes_reg[1] <= s_tdata[pusb_pkg::FMT_W +     BW +: BW];
            bytes_reg[2] <= s_tdata[pusb_pkg::FMT_W + 2 * BW +: BW];
            bytes_reg[3] <= s_tdata[pusb_pkg::FMT_W + 3 * BW +: BW];
        end
    end

    // ---- format expansion to RGBA ----
    logic [BW-1:0] chan_in [pusb_pkg::NUM_CHAN];

    always_comb
    begin
        case (fmt_reg)
            pusb_pkg::FMT_RGBA:
            begin
                chan_in[pusb_pkg::CH_RED]   = bytes_reg[0];
                chan_in[pusb_pkg::CH_GREEN] = bytes_reg[1];
                chan_in[pusb_pkg::CH_BLUE]  = bytes_reg[2];
                chan_in[pusb_pkg::CH_ALPHA] = bytes_reg[3];
            end
            pusb_pkg::FMT_BGRA:
            begin
                chan_in[pusb_pkg::CH_RED]   = bytes_reg[2];
                chan_in[pusb_pkg::CH_GREEN] = bytes_reg[1];
                chan_in[pusb_pkg::CH_BLUE]  = bytes_reg[0];
                chan_in[pusb_pkg::CH_ALPHA] = bytes_reg[3];
            end
            pusb_pkg::FMT_RGB:
            begin
                chan_in[pusb_pkg::CH_RED]   = bytes_reg[0];
                chan_in[pusb_pkg::CH_GREEN] = bytes_reg[1];
                chan_in[pusb_pkg::CH_BLUE]  = bytes_reg[2];
                chan_in[pusb_pkg::CH_ALPHA] = pusb_pkg::ALPHA_OPAQUE;
            end
            pusb_pkg::FMT_LUM:
            begin
                chan_in[pusb_pkg::CH_RED]   = bytes_reg[0];
                chan_in[pusb_pkg::CH_GREEN] = bytes_reg[0];
                chan_in[pusb_pkg::CH_BLUE]  = bytes_reg[0];
                chan_in[pusb_pkg::CH_ALPHA] = pusb_pkg::ALPHA_OPAQUE;
            end
            default:
            begin
                // alpha-only, and the unused codes decode the same way
                chan_in[pusb_pkg::CH_RED]   = pusb_pkg::CHAN_ZERO;
                chan_in[pusb_pkg::CH_GREEN] = pusb_pkg::CHAN_ZERO;
                chan_in[pusb_pkg::CH_BLUE]  = pusb_pkg::CHAN_ZERO;
                chan_in[pusb_pkg::CH_ALPHA] = bytes_reg[0];
            end
        endcase
    end

    // ---- per-channel scale/bias ----
    logic [BW-1:0] chan_out [pusb_pkg::NUM_CHAN];

    for (genvar c = 0; c < pusb_pkg::NUM_CHAN; c++)
    begin : g_chan
        pusb_channel u_channel (
            .value  (chan_in[c]),
            .scale  (scale_reg[c]),
            .bias   (bias_reg[c]),
            .result (chan_out[c])
        );
    end

    // ---- result register ----
    logic [pusb_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic [pusb_pkg::OUT_TDATA_W-1:0] out_data_next;

    assign out_data_next = {chan_out[3], chan_out[2], chan_out[1], chan_out[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    // a full pipeline behind a stalled output must push back on the input
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
    else $error("input accepted while both stages are full and stalled");

    // an accepted word always lands in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> in_valid_reg)
    else $error("accepted word lost at input register");

    // a word in the input register moves to the output when the output frees up
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && advance) |=> m_tvalid)
    else $error("word dropped between input and result register");

    // output can only become valid if a word sat in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(in_valid_reg))
    else $error("result appeared without a source word");
`endif

endmodule
